### src/mtk_pkg.sv
// Package for the multi-tap keypad text entry unit.
// Holds the command and state types, the codes and the key letter table.
// No dependencies.
package mtk_pkg;

   localparam int LINE_LENGTH_DEFAULT = 32;
   localparam int CMD_QUEUE_DEPTH     = 2;

   localparam logic [8:0]  MASK_CLEAR = 9'h0C0;
   localparam logic [8:0]  MASK_MODE  = 9'h018;
   localparam logic [8:0]  MASK_SPACE = 9'h003;
   localparam logic [13:0] PRESS_MAX  = 14'd9999;
   localparam logic [7:0]  CHAR_EMPTY = 8'h00;
   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_RESET,
      CMD_CLEAR,
      CMD_MODE,
      CMD_SPACE,
      CMD_KEY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   key_sel;
   } key_cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_APPLY,
      BK_STREAM
   } back_state_type;

   // Letter in slot 0..2 of switch 1..9
   function automatic logic [7:0] key_letter(input logic [3:0] key_sel,
                                             input logic [1:0] slot);
      logic [23:0] row;
      case (key_sel)
         4'd1: row = {8'h2E, 8'h51, 8'h5A};   // . Q Z
         4'd2: row = {8'h41, 8'h42, 8'h43};   // A B C
         4'd3: row = {8'h44, 8'h45, 8'h46};   // D E F
         4'd4: row = {8'h47, 8'h48, 8'h49};   // G H I
         4'd5: row = {8'h4A, 8'h4B, 8'h4C};   // J K L
         4'd6: row = {8'h4D, 8'h4E, 8'h4F};   // M N O
         4'd7: row = {8'h50, 8'h52, 8'h53};   // P R S
         4'd8: row = {8'h54, 8'h55, 8'h56};   // T U V
         4'd9: row = {8'h57, 8'h58, 8'h59};   // W X Y
         default: row = 24'h000000;
      endcase
      case (slot)
         2'd0: key_letter = row[23:16];
         2'd1: key_letter = row[15:8];
         default: key_letter = row[7:0];
      endcase
   endfunction

endpackage

### src/mtk_front.sv
// Front end: accepts press transactions and classifies them into commands.
// Depends on mtk_pkg; feeds mtk_queue.
module mtk_front (
   input  logic                 req_valid,
   input  logic                 req_key_valid,
   input  logic                 req_reset_key,
   input  logic [8:0]           req_switch_mask,
   input  logic                 q_full,
   output logic                 req_stall,
   output logic                 push,
   output mtk_pkg::key_cmd_type cmd
);
   import mtk_pkg::*;

   logic [3:0] single_sw;

   always_comb begin
      single_sw = 4'd0;
      for (int n = 1; n <= 9; n++) begin
         if (req_switch_mask == 9'(1 << (9 - n))) begin
            single_sw = 4'(n);
         end
      end
   end

   always_comb begin
      cmd.key_sel = single_sw;
      if (!req_key_valid) begin
         cmd.kind = CMD_NONE;
      end else if (req_reset_key) begin
         cmd.kind = CMD_RESET;
      end else if (req_switch_mask == MASK_CLEAR) begin
         cmd.kind = CMD_CLEAR;
      end else if (req_switch_mask == MASK_MODE) begin
         cmd.kind = CMD_MODE;
      end else if (req_switch_mask == MASK_SPACE) begin
         cmd.kind = CMD_SPACE;
      end else if (single_sw != 4'd0) begin
         cmd.kind = CMD_KEY;
      end else begin
         cmd.kind = CMD_NONE;
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

endmodule

### src/mtk_queue.sv
// Short command queue between the front end and the back end.
// Depends on mtk_pkg.
module mtk_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mtk_pkg::key_cmd_type push_cmd,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output mtk_pkg::key_cmd_type head
);
   import mtk_pkg::*;

   localparam int PtrW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(CMD_QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(CMD_QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(CMD_QUEUE_DEPTH);

   key_cmd_type     entries_ff [CMD_QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full  = (count_ff == CntFull);
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

endmodule

### src/mtk_back.sv
// Back end: executes commands on the line store and streams the line out.
// The line is a circular buffer with per-entry valid bits. Depends on mtk_pkg.
module mtk_back #(
   parameter int LINE_LENGTH = mtk_pkg::LINE_LENGTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  mtk_pkg::key_cmd_type q_head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [4:0]           rsp_position,
   output logic [7:0]           rsp_character,
   output logic [13:0]          rsp_press_count,
   output logic                 rsp_numeric_mode,
   output logic                 rsp_last,
   output logic [$clog2(LINE_LENGTH+1)-1:0] write_index
);
   import mtk_pkg::*;

   localparam int PW = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
   localparam int IW = $clog2(LINE_LENGTH + 1);
   localparam logic [PW:0]   LenP    = (PW+1)'(LINE_LENGTH);
   localparam logic [IW-1:0] LenI    = IW'(LINE_LENGTH);
   localparam logic [IW-1:0] LastIdx = IW'(LINE_LENGTH - 1);
   localparam logic [PW-1:0] LastPos = PW'(LINE_LENGTH - 1);

   back_state_type state_ff, state_in;
   key_cmd_type    cmd_ff;

   logic [PW-1:0]          base_ff, base_in;
   logic [IW-1:0]          idx_ff, idx_in, idx_next;
   logic [13:0]            presses_ff, presses_in, press_inc;
   logic                   mode_ff, mode_in;
   logic [LINE_LENGTH-1:0] valid_ff, valid_in;
   logic [7:0]             line_mem [LINE_LENGTH];

   logic [7:0]    rd_data_ff;
   logic          rd_vbit_ff;
   logic          rd_valid_ff;
   logic [PW-1:0] rd_pos_ff;
   logic [IW-1:0] rd_cnt_ff;

   logic [4:0]  rsp_position_ff;
   logic [7:0]  rsp_character_ff;
   logic [13:0] rsp_press_count_ff;
   logic        rsp_numeric_mode_ff;
   logic        rsp_last_ff;
   logic        rsp_valid_ff;

   logic          load, issue, rd_en;
   logic [PW-1:0] rd_addr, prev_addr;
   logic          wr_en, clear_all, scroll;
   logic [PW-1:0] wr_off, wr_addr;
   logic [7:0]    wr_char, prev_char, letter0, letter1, letter2;

   function automatic logic [PW-1:0] phys(input logic [PW-1:0] b,
                                          input logic [PW-1:0] off);
      logic [PW:0] s;
      s = {1'b0, b} + {1'b0, off};
      if (s >= LenP) begin
         s = s - LenP;
      end
      return s[PW-1:0];
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = BK_APPLY;
            end
         end
         BK_APPLY: state_in = BK_STREAM;
         BK_STREAM: begin
            if (load && rd_pos_ff == LastPos) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      load      = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
      pop       = (state_ff == BK_IDLE) && !q_empty;
      issue     = (state_ff == BK_STREAM) && (rd_cnt_ff != LenI) && (!rd_valid_ff || load);
      rd_en     = pop || issue;
      prev_addr = phys(base_ff, PW'(idx_ff - 1'b1));
      rd_addr   = (state_ff == BK_STREAM) ? phys(base_ff, PW'(rd_cnt_ff)) : prev_addr;
   end

   // command execution
   always_comb begin
      prev_char  = rd_vbit_ff ? rd_data_ff : CHAR_EMPTY;
      letter0    = key_letter(cmd_ff.key_sel, 2'd0);
      letter1    = key_letter(cmd_ff.key_sel, 2'd1);
      letter2    = key_letter(cmd_ff.key_sel, 2'd2);
      press_inc  = (presses_ff == PRESS_MAX) ? 14'd0 : presses_ff + 14'd1;
      idx_next   = idx_ff;
      presses_in = presses_ff;
      mode_in    = mode_ff;
      wr_en      = 1'b0;
      wr_off     = PW'(idx_ff);
      wr_char    = CHAR_EMPTY;
      clear_all  = 1'b0;
      if (state_ff == BK_APPLY) begin
         case (cmd_ff.kind)
            CMD_RESET: begin
               clear_all  = 1'b1;
               idx_next   = '0;
               presses_in = '0;
               mode_in    = 1'b0;
            end
            CMD_CLEAR: begin
               clear_all  = 1'b1;
               idx_next   = '0;
               presses_in = '0;
            end
            CMD_MODE: mode_in = !mode_ff;
            CMD_SPACE: begin
               wr_en      = 1'b1;
               wr_char    = CHAR_SPACE;
               idx_next   = idx_ff + 1'b1;
               presses_in = press_inc;
            end
            CMD_KEY: begin
               presses_in = press_inc;
               wr_en      = 1'b1;
               if (mode_ff) begin
                  wr_char  = CHAR_ZERO + {4'd0, cmd_ff.key_sel};
                  idx_next = idx_ff + 1'b1;
               end else if (idx_ff == '0) begin
                  wr_char  = letter0;
                  idx_next = idx_ff + 1'b1;
               end else if (prev_char == letter0) begin
                  wr_off  = PW'(idx_ff - 1'b1);
                  wr_char = letter1;
               end else if (prev_char == letter1) begin
                  wr_off  = PW'(idx_ff - 1'b1);
                  wr_char = letter2;
               end else begin
                  wr_char  = letter0;
                  idx_next = idx_ff + 1'b1;
               end
            end
            default: idx_next = idx_ff;
         endcase
      end
      wr_addr = phys(base_ff, wr_off);
      scroll  = (state_ff == BK_APPLY) && (idx_next == LenI);
      idx_in  = scroll ? LastIdx : idx_next;
      base_in = base_ff;
      if (scroll) begin
         base_in = (base_ff == LastPos) ? '0 : base_ff + 1'b1;
      end
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else begin
         if (wr_en) begin
            valid_in[wr_addr] = 1'b1;
         end
         if (scroll) begin
            valid_in[base_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         base_ff      <= '0;
         idx_ff       <= '0;
         presses_ff   <= '0;
         mode_ff      <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         base_ff    <= base_in;
         idx_ff     <= idx_in;
         presses_ff <= presses_in;
         mode_ff    <= mode_in;
         valid_ff   <= valid_in;
         if (state_ff == BK_APPLY) begin
            rd_cnt_ff <= '0;
         end else if (issue) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
         if (issue) begin
            rd_valid_ff <= 1'b1;
         end else if (load) begin
            rd_valid_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= q_head;
      end
      if (wr_en) begin
         line_mem[wr_addr] <= wr_char;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
         rd_vbit_ff <= valid_ff[rd_addr];
      end
      if (issue) begin
         rd_pos_ff <= PW'(rd_cnt_ff);
      end
      if (load) begin
         rsp_position_ff     <= 5'(rd_pos_ff);
         rsp_character_ff    <= rd_vbit_ff ? rd_data_ff : CHAR_EMPTY;
         rsp_press_count_ff  <= presses_ff;
         rsp_numeric_mode_ff <= mode_ff;
         rsp_last_ff         <= (rd_pos_ff == LastPos);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_character    = rsp_character_ff;
   assign rsp_press_count  = rsp_press_count_ff;
   assign rsp_numeric_mode = rsp_numeric_mode_ff;
   assign rsp_last         = rsp_last_ff;
   assign write_index      = idx_ff;

endmodule

### src/multitap_keypad_text_entry_unit.sv
// Multi-tap keypad text entry unit, top level.
// Instantiates mtk_front, mtk_queue and mtk_back; depends on mtk_pkg.
//
// Usage:
//  - req channel: one press event per transaction (key_valid, reset_key,
//    switch_mask). A transaction with key_valid low only refreshes the line.
//  - rsp channel: every request produces LINE_LENGTH transactions, one per
//    character position in order, each with the press count and the mode;
//    rsp_last marks the final position.
//  - A two-entry command queue sits between the classifier and the executor,
//    so up to two requests are taken while a line is still streaming.
//  - A request passes the queue, the command register and the apply step;
//    its characters then pass the line store read register and the output
//    register. The line store has a single read port, which delivers one
//    character per cycle while the receiver does not stall.
//  - When the receiver stalls, the output register holds its character and
//    the stream pauses; the queue fills and then req_stall rises.
//  - Reset (synchronous, active high) empties the queue, clears the line,
//    the write index and the press count, and selects letter mode.
module multitap_keypad_text_entry_unit #(
   parameter int LINE_LENGTH = mtk_pkg::LINE_LENGTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_key_valid,
   input  logic        req_reset_key,
   input  logic [8:0]  req_switch_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_position,
   output logic [7:0]  rsp_character,
   output logic [13:0] rsp_press_count,
   output logic        rsp_numeric_mode,
   output logic        rsp_last
);
   import mtk_pkg::*;

   logic        push, pop, q_full, q_empty;
   key_cmd_type push_cmd, q_head;
   logic [$clog2(LINE_LENGTH+1)-1:0] bk_write_index;

   mtk_front u_front (
      .req_valid       (req_valid),
      .req_key_valid   (req_key_valid),
      .req_reset_key   (req_reset_key),
      .req_switch_mask (req_switch_mask),
      .q_full          (q_full),
      .req_stall       (req_stall),
      .push            (push),
      .cmd             (push_cmd)
   );

   mtk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   mtk_back #(
      .LINE_LENGTH (LINE_LENGTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_character    (rsp_character),
      .rsp_press_count  (rsp_press_count),
      .rsp_numeric_mode (rsp_numeric_mode),
      .rsp_last         (rsp_last),
      .write_index      (bk_write_index)
   );

   a_index_in_line: assert property (@(posedge clock) disable iff (reset)
      bk_write_index < LINE_LENGTH)
      else $error("write index left the line");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_press_count <= PRESS_MAX)
      else $error("press count out of range");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_position == 5'(LINE_LENGTH - 1))
      else $error("last flag on wrong position");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position) &&
      $stable(rsp_character) && $stable(rsp_press_count) && $stable(rsp_last))
      else $error("stalled transaction changed");

endmodule

### sim/tb_multitap_keypad_text_entry_unit.sv
// Testbench for multitap_keypad_text_entry_unit: directed table, then random press events.
// Each accepted event is run through a local model of the keypad line; every streamed
// character is checked in order. Depends on mtk_pkg and the RTL under src/.
module tb_multitap_keypad_text_entry_unit;
   import mtk_pkg::*;

   localparam int LINE_LEN     = LINE_LENGTH_DEFAULT;
   localparam int NUM_DIRECTED = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam string KEY_LETTERS = ".QZABCDEFGHIJKLMNOPRSTUVWXY";

   typedef struct packed {
      logic [4:0]  position;
      logic [7:0]  character;
      logic [13:0] press_count;
      logic        numeric_mode;
      logic        last;
   } line_char_type;

   typedef struct packed {
      logic       key_valid;
      logic       reset_key;
      logic [8:0] switch_mask;
      logic       typed;
      logic [7:0] char0;
      logic [13:0] count;
      logic       mode;
   } press_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_key_valid;
   logic        req_reset_key;
   logic [8:0]  req_switch_mask;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_position;
   logic [7:0]  rsp_character;
   logic [13:0] rsp_press_count;
   logic        rsp_numeric_mode;
   logic        rsp_last;

   multitap_keypad_text_entry_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_valid    (req_key_valid),
      .req_reset_key    (req_reset_key),
      .req_switch_mask  (req_switch_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_character    (rsp_character),
      .rsp_press_count  (rsp_press_count),
      .rsp_numeric_mode (rsp_numeric_mode),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // local copy of the line state
   logic [7:0]  line_mem [LINE_LEN];
   int unsigned wr_idx;
   logic [13:0] press_cnt;
   logic        digit_md;

   line_char_type line_expect_q [$];
   line_char_type expected_char;
   int          mismatches = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          hold_left = 0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   int          last_sw = 1;

   press_row_type directed_rows [NUM_DIRECTED] = '{
      '{1'b0, 1'b0, 9'h000, 1'b1, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h100, 1'b1, ".",   14'd1, 1'b0},
      '{1'b1, 1'b0, 9'h100, 1'b1, "Q",   14'd2, 1'b0},
      '{1'b1, 1'b0, 9'h100, 1'b1, "Z",   14'd3, 1'b0},
      '{1'b1, 1'b0, 9'h100, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h001, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h003, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h018, 1'b1, "Z",   14'd6, 1'b1},
      '{1'b1, 1'b0, 9'h010, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h100, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h001, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h018, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h000, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h1FF, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h0C1, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b0, 1'b1, 9'h0C0, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h0C0, 1'b1, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h080, 1'b1, "A",   14'd1, 1'b0},
      '{1'b1, 1'b0, 9'h080, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h040, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h018, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b1, 9'h018, 1'b1, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b0, 9'h002, 1'b0, 8'h00, 14'd0, 1'b0},
      '{1'b1, 1'b1, 9'h000, 1'b1, 8'h00, 14'd0, 1'b0}
   };

   task automatic clear_line();
      for (int i = 0; i < LINE_LEN; i++) line_mem[i] = CHAR_EMPTY;
      wr_idx = 0;
      press_cnt = '0;
   endtask

   task automatic count_press();
      press_cnt = (press_cnt == PRESS_MAX) ? 14'd0 : press_cnt + 14'd1;
   endtask

   task automatic append_char(input logic [7:0] c);
      if (wr_idx < LINE_LEN) line_mem[wr_idx] = c;
      wr_idx++;
   endtask

   // apply one press event and queue the streamed line it produces
   task automatic enter_press(input logic kv, input logic rk, input logic [8:0] m);
      int sw;
      logic [7:0] first, second, prev;
      line_char_type c;
      sw = 0;
      for (int n = 1; n <= 9; n++) if (m == (9'h100 >> (n - 1))) sw = n;
      if (kv) begin
         if (rk) begin
            clear_line();
            digit_md = 1'b0;
         end else if (m == MASK_CLEAR) begin
            clear_line();
         end else if (m == MASK_MODE) begin
            digit_md = ~digit_md;
         end else if (m == MASK_SPACE) begin
            append_char(CHAR_SPACE);
            count_press();
         end else if (sw != 0) begin
            first = KEY_LETTERS[(sw - 1) * 3];
            second = KEY_LETTERS[(sw - 1) * 3 + 1];
            count_press();
            if (digit_md) begin
               append_char(CHAR_ZERO + 8'(sw));
            end else if (wr_idx == 0 || wr_idx > LINE_LEN) begin
               append_char(first);
            end else begin
               prev = line_mem[wr_idx - 1];
               if (prev == first) line_mem[wr_idx - 1] = second;
               else if (prev == second) line_mem[wr_idx - 1] = KEY_LETTERS[(sw - 1) * 3 + 2];
               else append_char(first);
            end
         end
      end
      if (wr_idx >= LINE_LEN) begin
         for (int i = 0; i < LINE_LEN - 1; i++) line_mem[i] = line_mem[i + 1];
         line_mem[LINE_LEN - 1] = CHAR_EMPTY;
         wr_idx = LINE_LEN - 1;
      end
      for (int i = 0; i < LINE_LEN; i++) begin
         c.position = 5'(i);
         c.character = line_mem[i];
         c.press_count = press_cnt;
         c.numeric_mode = digit_md;
         c.last = (i == LINE_LEN - 1);
         line_expect_q.push_back(c);
      end
   endtask

   // offer one transaction; valid stays high across back-to-back transactions
   task automatic offer(input logic kv, input logic rk, input logic [8:0] m);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_valid <= kv;
      req_reset_key <= rk;
      req_switch_mask <= m;
      do @(posedge clock); while (req_stall);
      enter_press(kv, rk, m);
   endtask

   // mostly well-formed multi-tap sequences, some chords, noise and refreshes
   task automatic random_press(input bit allow_clear);
      int r;
      logic kv, rk;
      logic [8:0] m;
      r = $urandom_range(0, 99);
      kv = 1'b1;
      rk = 1'b0;
      if (r < 55) begin
         if ($urandom_range(0, 2) == 0) last_sw = $urandom_range(1, 9);
         m = 9'h100 >> (last_sw - 1);
      end else if (r < 63) begin
         m = MASK_SPACE;
      end else if (r < 69) begin
         m = MASK_MODE;
      end else if (r < 72 && allow_clear) begin
         m = MASK_CLEAR;
      end else if (r < 74 && allow_clear) begin
         rk = 1'b1;
         m = 9'($urandom_range(0, 511));
      end else if (r < 84) begin
         kv = 1'b0;
         rk = 1'($urandom_range(0, 1));
         m = 9'($urandom_range(0, 511));
      end else begin
         m = 9'($urandom_range(0, 511));
      end
      offer(kv, rk, m);
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (line_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: pos %0d char %h count %0d mode %b last %b",
                        rsp_position, rsp_character, rsp_press_count, rsp_numeric_mode,
                        rsp_last);
         end else begin
            expected_char = line_expect_q.pop_front();
            if (rsp_position !== expected_char.position ||
                rsp_character !== expected_char.character ||
                rsp_press_count !== expected_char.press_count ||
                rsp_numeric_mode !== expected_char.numeric_mode ||
                rsp_last !== expected_char.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %h %0d %b %b, got %0d %h %0d %b %b",
                           expected_char.position, expected_char.character,
                           expected_char.press_count, expected_char.numeric_mode,
                           expected_char.last, rsp_position, rsp_character,
                           rsp_press_count, rsp_numeric_mode, rsp_last);
            end
         end
      end
   end

   initial begin
      #80_000_000;
      $display("[multitap_keypad_text_entry_unit] ERROR");
      $finish;
   end

   initial begin
      line_char_type row_char;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_key_valid <= 1'b0;
      req_reset_key <= 1'b0;
      req_switch_mask <= '0;
      clear_line();
      digit_md = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 17;
      rx_idle_pct = 62;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         offer(directed_rows[i].key_valid, directed_rows[i].reset_key,
               directed_rows[i].switch_mask);
         if (directed_rows[i].typed) begin
            row_char = line_expect_q[line_expect_q.size() - LINE_LEN];
            row_char.character = directed_rows[i].char0;
            row_char.press_count = directed_rows[i].count;
            row_char.numeric_mode = directed_rows[i].mode;
            line_expect_q[line_expect_q.size() - LINE_LEN] = row_char;
         end
      end
      for (int i = 0; i < 120; i++) begin
         if (i == 30) hold_go <= 1'b1;
         random_press(1'b1);
      end

      tx_idle_pct = 62;
      rx_idle_pct = 17;
      for (int i = 0; i < 115; i++) random_press(1'b1);

      // no clears here: the line fills and scrolls
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      for (int i = 0; i < 115; i++) random_press(1'b0);

      req_valid <= 1'b0;
      while (line_expect_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("[multitap_keypad_text_entry_unit] OK");
      else
         $display("[multitap_keypad_text_entry_unit] ERROR");
      $finish;
   end

endmodule
